// File: rtl/round_robin_task_scheduler_top_macros.svh
`ifndef ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH

// Checked on every edge, reset included.
`define RRTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define RRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 4;
  localparam int CTX_W     = 32;

  typedef enum logic [1:0] {
    CMD_SPAWN    = 2'd0,
    CMD_START    = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_KILL     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RC_OK         = 2'd0,
    RC_FULL       = 2'd1,
    RC_NO_READY   = 2'd2,
    RC_NO_CURRENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DYING   = 2'd3
  } slot_state_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } fsm_t;

  typedef struct packed {
    cmd_t              command;
    logic [CTX_W-1:0]  entry_address;
    logic [CTX_W-1:0]  frame_pointer;
  } sched_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CTX_W-1:0]  context_value;
    logic              fresh;
    status_t           status_code;
  } sched_out_t;

  // decision of the slot table for one command beat
  typedef struct packed {
    status_t rc;
    logic    rd_en;      // context of the picked slot comes from the RAM
    logic    wr_en;      // context write this beat
    logic    fwd;        // read and write hit the same entry
    logic    ctx_entry;  // spawn: result carries the entry address
  } ctl_t;

endpackage
`default_nettype wire

// File: rtl/round_robin_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Round-robin task-slot scheduler.
// Command channel (cmd_valid/cmd_ready/cmd): one beat is spawn, start,
// schedule or kill. Result channel (res_valid/res_ready/res): exactly one
// beat per command, in command order.
// Slot states live in flip-flops and are searched by priority encoders in
// the accept cycle; saved contexts and fresh flags live in a synchronous
// RAM that is written and read in that same cycle.
// The result beat is built from the registered decision and RAM read data,
// then loaded into the output register. Commands are taken only in S_IDLE,
// so none enters while one is in S_BUSY; a new command is taken as soon as
// the previous result is in the output register, even while that result
// still waits for res_ready. A stalled receiver holds the result; the next
// command then waits in S_BUSY until the output register frees up.
// Reset (rst, synchronous, active high): all slots free, no current task,
// first switch pending, result channel empty. No clearing pass is needed.
module round_robin_task_scheduler_top #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output      logic                 cmd_ready,
  input  wire rrts_pkg::sched_in_t  cmd,
  output      logic                 res_valid,
  input  wire logic                 res_ready,
  output      rrts_pkg::sched_out_t res
);

  localparam int IW = $clog2(SLOTS);
  localparam int DW = rrts_pkg::CTX_W + 1;

  rrts_pkg::fsm_t state, state_next;
  rrts_pkg::ctl_t ctl, pend_ctl;
  logic [IW-1:0]  pick_idx, wr_idx, pend_idx;
  logic [rrts_pkg::CTX_W-1:0] pend_ctx;
  logic [DW-1:0]  wdata, rdata;
  logic           accept, load;
  logic [IW+rrts_pkg::SLOT_W-1:0] slot_ext;
  rrts_pkg::sched_out_t res_next;

  assign accept = cmd_valid && cmd_ready;

  rrts_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .command  (cmd.command),
    .ctl      (ctl),
    .pick_idx (pick_idx),
    .wr_idx   (wr_idx)
  );

  assign wdata = ctl.ctx_entry ? {cmd.entry_address, 1'b1} : {cmd.frame_pointer, 1'b0};

  rrts_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_ctx_ram (
    .clk   (clk),
    .we    (accept && ctl.wr_en),
    .waddr (wr_idx),
    .wdata (wdata),
    .re    (accept && ctl.rd_en),
    .raddr (pick_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ctl <= ctl;
      pend_idx <= pick_idx;
      pend_ctx <= ctl.ctx_entry ? cmd.entry_address : cmd.frame_pointer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    load       = 1'b0;
    unique case (state)
      rrts_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = rrts_pkg::S_BUSY;
      end
      rrts_pkg::S_BUSY: begin
        load = !res_valid || res_ready;
        if (load) state_next = rrts_pkg::S_IDLE;
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    slot_ext = {{rrts_pkg::SLOT_W{1'b0}}, pend_idx};
    res_next = '{status_code: pend_ctl.rc, default: '0};
    if (pend_ctl.rc == rrts_pkg::RC_OK) begin
      res_next.slot = slot_ext[rrts_pkg::SLOT_W-1:0];
      if (pend_ctl.ctx_entry) begin
        res_next.context_value = pend_ctx;
        res_next.fresh         = 1'b1;
      end else if (pend_ctl.fwd) begin
        // old slot picked again: it gets the frame just saved
        res_next.context_value = pend_ctx;
        res_next.fresh         = 1'b0;
      end else if (pend_ctl.rd_en) begin
        res_next.context_value = rdata[DW-1:1];
        res_next.fresh         = rdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rrts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rrts_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
module rrts_slot_table #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire rrts_pkg::cmd_t           command,
  output      rrts_pkg::ctl_t           ctl,
  output      logic [$clog2(SLOTS)-1:0] pick_idx,
  output      logic [$clog2(SLOTS)-1:0] wr_idx
);

  localparam int IW = $clog2(SLOTS);

  rrts_pkg::slot_state_t status [SLOTS];
  logic [IW-1:0]         cur;
  logic                  have;
  logic                  first;

  logic [SLOTS-1:0] free_vec, ready_vec, eff_vec, above_vec;
  logic [IW-1:0]    free_idx, ready_idx, eff_idx, up_idx;
  logic             cur_run;

  always_comb begin
    cur_run = (status[cur] == rrts_pkg::ST_RUNNING);
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i]  = (status[i] == rrts_pkg::ST_FREE);
      ready_vec[i] = (status[i] == rrts_pkg::ST_READY);
      // old slot counts as ready when running; it comes last in the circle
      eff_vec[i]   = ready_vec[i] | (cur_run && (IW'(i) == cur));
      above_vec[i] = eff_vec[i] && (i > int'(cur));
    end
    free_idx  = '0;
    ready_idx = '0;
    eff_idx   = '0;
    up_idx    = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i])  free_idx  = IW'(i);
      if (ready_vec[i]) ready_idx = IW'(i);
      if (eff_vec[i])   eff_idx   = IW'(i);
      if (above_vec[i]) up_idx    = IW'(i);
    end
  end

  always_comb begin
    ctl      = '{rc: rrts_pkg::RC_OK, default: 1'b0};
    pick_idx = '0;
    wr_idx   = cur;
    unique case (command)
      rrts_pkg::CMD_SPAWN: begin
        if (|free_vec) begin
          pick_idx      = free_idx;
          wr_idx        = free_idx;
          ctl.wr_en     = 1'b1;
          ctl.ctx_entry = 1'b1;
        end else begin
          ctl.rc = rrts_pkg::RC_FULL;
        end
      end
      rrts_pkg::CMD_START: begin
        if (|ready_vec) begin
          pick_idx  = ready_idx;
          ctl.rd_en = 1'b1;
        end else begin
          ctl.rc = rrts_pkg::RC_NO_READY;
        end
      end
      rrts_pkg::CMD_SCHEDULE: begin
        if (!have) begin
          ctl.rc = rrts_pkg::RC_NO_CURRENT;
        end else if (!(|eff_vec)) begin
          ctl.rc = rrts_pkg::RC_NO_READY;
        end else begin
          pick_idx  = (|above_vec) ? up_idx : eff_idx;
          ctl.rd_en = 1'b1;
          ctl.wr_en = !first;
          ctl.fwd   = !first && (pick_idx == cur);
        end
      end
      rrts_pkg::CMD_KILL: begin
        if (!have) begin
          ctl.rc = rrts_pkg::RC_NO_CURRENT;
        end else begin
          pick_idx = cur;
        end
      end
      default: ctl.rc = rrts_pkg::RC_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= rrts_pkg::ST_FREE;
      end
      cur   <= '0;
      have  <= 1'b0;
      first <= 1'b1;
    end else if (accept && ctl.rc == rrts_pkg::RC_OK) begin
      unique case (command)
        rrts_pkg::CMD_SPAWN: begin
          status[pick_idx] <= rrts_pkg::ST_READY;
        end
        rrts_pkg::CMD_START: begin
          if (have && cur_run) status[cur] <= rrts_pkg::ST_READY;
          status[pick_idx] <= rrts_pkg::ST_RUNNING;
          cur  <= pick_idx;
          have <= 1'b1;
        end
        rrts_pkg::CMD_SCHEDULE: begin
          // old slot picked again just stays running
          if (cur_run && pick_idx != cur) status[cur] <= rrts_pkg::ST_READY;
          status[pick_idx] <= rrts_pkg::ST_RUNNING;
          cur   <= pick_idx;
          first <= 1'b0;
        end
        rrts_pkg::CMD_KILL: begin
          status[cur] <= rrts_pkg::ST_DYING;
        end
        default: cur <= cur;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/rrts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_task_scheduler_top_macros.svh"
module rrts_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cmd_valid,
  input wire logic                 cmd_ready,
  input wire logic                 res_valid,
  input wire logic                 res_ready,
  input wire rrts_pkg::sched_out_t res
);

  `RRTS_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid, "result valid right after reset")

  `RRTS_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable(res), "stalled result beat changed")

  `RRTS_ASSERT(a_one_at_a_time, cmd_valid && cmd_ready |=> !cmd_ready, "command taken on back-to-back cycles")

  `RRTS_ASSERT(a_fail_zero, res_valid && res.status_code != rrts_pkg::RC_OK |-> res.slot == '0 && res.context_value == '0 && !res.fresh, "failed result carries data")

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire
